// ===== rtl/core/tef_pkg.sv =====
// Shared types and constants for the trapezoidal energy filter.
// Used by tef_mac and trapezoidal_energy_filter_top; depends on nothing.
`timescale 1ns / 1ps

package tef_pkg;

    // Sample history; the depth must be a power of two.
    localparam int HIST_DEPTH  = 1024;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int SAMPLE_BITS = 16;

    // Field and state widths.
    localparam int IN_W    = 16;
    localparam int OUT_W   = 48;
    localparam int SUM_W   = 24;
    localparam int FILL_W  = 10;
    localparam int CD_W    = 9;
    localparam int AGE_W   = 10;
    localparam int LEN_W   = 8;
    localparam int BASE_W  = 20;
    localparam int LCOEF_W = 26;
    localparam int TCOEF_W = 25;
    localparam int TRIG_W  = 16;
    localparam int LBASE_W = LEN_W + BASE_W;
    localparam int CFG_W   = 26;
    localparam int CFG_IW  = 3;

    localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        CFG_RISE_LEN   = 3'd0,
        CFG_GAP_LEN    = 3'd1,
        CFG_BASELINE   = 3'd2,
        CFG_LEAD_COEF  = 3'd3,
        CFG_TRAIL_COEF = 3'd4,
        CFG_TRIGGER    = 3'd5
    } t_cfg_index;

    // One input item.
    typedef struct packed {
        logic [IN_W-1:0] sample;
        logic            trace_start;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [OUT_W-1:0] filter_value;
        logic signed [OUT_W-1:0] energy;
        logic                    energy_valid;
    } t_out_item;

    // Raw window sums handed to the multiply-accumulate pipeline.
    typedef struct packed {
        logic [SUM_W-1:0] lead;
        logic [SUM_W-1:0] gap;
        logic [SUM_W-1:0] trail;
    } t_sums;

    // Static weights and baseline products for the multiply-accumulate pipeline.
    typedef struct packed {
        logic signed [LCOEF_W-1:0] lead_coef;
        logic [TCOEF_W-1:0]        trail_coef;
        logic [LBASE_W-1:0]        lbase;
        logic [LBASE_W-1:0]        gbase;
    } t_mac_cfg;

endpackage

// ===== rtl/core/trapezoidal_energy_filter_top.sv =====
// Top level of the trapezoidal energy filter: sample ring, window sums and pick.
// Depends on tef_pkg and tef_mac.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_item (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled. Each item passes through the
// ring read, the sum update, the three stages of the weighting pipeline and the
// output register. The two ring copies give three reads a cycle.
// A result waiting at the output freezes the whole pipeline, and the input is
// taken only when the output register is free or being emptied.
// Reset clears control state; the ring needs no clearing pass.

module trapezoidal_energy_filter_top import tef_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int CW = (HIST_AW > AGE_W) ? HIST_AW : AGE_W;

    // Configuration registers.
    logic [LEN_W-1:0]          r_rise_len, r_gap_len;
    logic [BASE_W-1:0]         r_baseline;
    logic signed [LCOEF_W-1:0] r_lead_coef;
    logic [TCOEF_W-1:0]        r_trail_coef;
    logic [TRIG_W-1:0]         r_trigger;
    logic [LBASE_W-1:0]        r_lbase, r_gbase;

    // Ring memories, two copies written alike.
    logic [SAMPLE_BITS-1:0] ring_a [HIST_DEPTH];
    logic [SAMPLE_BITS-1:0] ring_b [HIST_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_l, r_rd_lg, r_rd_llg;
    logic [HIST_AW-1:0]     r_pos;
    logic [FILL_W-1:0]      r_fill;

    // Pipeline control and payload.
    logic                   r_s1_valid, r_s1_ts, r_s1_full;
    logic [SAMPLE_BITS-1:0] r_s1_x;
    logic                   r_s1_use_l, r_s1_use_lg, r_s1_use_llg;
    logic                   r_s1_fwd_l, r_s1_fwd_lg, r_s1_fwd_llg;
    logic                   r_s2_valid, r_s2_ts, r_s2_full;
    logic                   r_s3_valid, r_s3_ts, r_s3_full;
    logic                   r_s4_valid, r_s4_ts, r_s4_full;
    logic                   r_s5_valid, r_s5_ts, r_s5_full;
    t_sums                  r_sums;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    // Pick state.
    logic                   r_armed, r_done;
    logic [CD_W-1:0]        r_cd;

    // Combinational signals.
    logic                   w_adv, w_accept;
    logic [LEN_W-1:0]       w_len_l;
    logic [AGE_W-1:0]       w_age_l, w_age_lg, w_age_llg;
    logic [CW-1:0]          w_age_l_x, w_age_lg_x, w_age_llg_x, w_pos_x;
    logic [HIST_AW-1:0]     w_pos_new, w_addr_l, w_addr_lg, w_addr_llg;
    logic [FILL_W-1:0]      w_fill_new;
    logic [SAMPLE_BITS-1:0] w_x, w_s_l, w_s_lg, w_s_llg;
    t_sums                  w_base, n_sums;
    t_mac_cfg               w_mac_cfg;
    logic signed [OUT_W-1:0] w_filt_raw, w_filt;
    logic                   w_trig;
    logic [CD_W-1:0]        w_delay;
    logic                   n_armed, n_done;
    logic [CD_W-1:0]        n_cd;
    logic                   n_evalid;

    // Handshake: the whole pipeline moves when the output slot is free or being emptied.
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign w_accept    = i_in_valid && w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_len   <= LEN_W'(27);
            r_gap_len    <= LEN_W'(16);
            r_baseline   <= '0;
            r_lead_coef  <= '0;
            r_trail_coef <= TCOEF_W'(65536);
            r_trigger    <= TRIG_W'(10);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RISE_LEN:   r_rise_len   <= i_cfg_data[LEN_W-1:0];
                CFG_GAP_LEN:    r_gap_len    <= i_cfg_data[LEN_W-1:0];
                CFG_BASELINE:   r_baseline   <= i_cfg_data[BASE_W-1:0];
                CFG_LEAD_COEF:  r_lead_coef  <= $signed(i_cfg_data[LCOEF_W-1:0]);
                CFG_TRAIL_COEF: r_trail_coef <= i_cfg_data[TCOEF_W-1:0];
                CFG_TRIGGER:    r_trigger    <= i_cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // Rise length zero behaves as one.
    assign w_len_l = (r_rise_len == '0) ? LEN_W'(1) : r_rise_len;

    // Baseline products, refreshed every cycle from the static registers.
    always_ff @(posedge i_clk) begin
        r_lbase <= LBASE_W'(w_len_l) * LBASE_W'(r_baseline);
        r_gbase <= LBASE_W'(r_gap_len) * LBASE_W'(r_baseline);
    end

    // Window ages, ring addresses and fill count for the incoming item.
    always_comb begin
        w_x         = i_in_item.sample[SAMPLE_BITS-1:0];
        w_age_l     = AGE_W'(w_len_l);
        w_age_lg    = AGE_W'(w_len_l) + AGE_W'(r_gap_len);
        w_age_llg   = AGE_W'(w_len_l) + w_age_lg;
        w_pos_new   = r_pos + HIST_AW'(1);
        w_pos_x     = CW'(w_pos_new);
        w_age_l_x   = CW'(w_age_l);
        w_age_lg_x  = CW'(w_age_lg);
        w_age_llg_x = CW'(w_age_llg);
        w_addr_l    = HIST_AW'(w_pos_x - w_age_l_x);
        w_addr_lg   = HIST_AW'(w_pos_x - w_age_lg_x);
        w_addr_llg  = HIST_AW'(w_pos_x - w_age_llg_x);
        if (i_in_item.trace_start) begin
            w_fill_new = FILL_W'(1);
        end else if (r_fill != FILL_MAX) begin
            w_fill_new = r_fill + FILL_W'(1);
        end else begin
            w_fill_new = r_fill;
        end
    end

    // Ring write and reads; an age that is a whole number of ring depths
    // means the sample being written, which is forwarded instead.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            ring_a[w_pos_new] <= w_x;
            ring_b[w_pos_new] <= w_x;
            r_rd_l            <= ring_a[w_addr_l];
            r_rd_lg           <= ring_a[w_addr_lg];
            r_rd_llg          <= ring_b[w_addr_llg];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
        end else if (w_accept) begin
            r_pos  <= w_pos_new;
            r_fill <= w_fill_new;
        end
    end

    // First stage: item payload beside the ring read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_x       <= w_x;
            r_s1_ts      <= i_in_item.trace_start;
            r_s1_full    <= w_fill_new >= FILL_W'(w_age_llg);
            r_s1_use_l   <= FILL_W'(w_age_l) < w_fill_new;
            r_s1_use_lg  <= FILL_W'(w_age_lg) < w_fill_new;
            r_s1_use_llg <= FILL_W'(w_age_llg) < w_fill_new;
            r_s1_fwd_l   <= w_age_l_x[HIST_AW-1:0] == '0;
            r_s1_fwd_lg  <= w_age_lg_x[HIST_AW-1:0] == '0;
            r_s1_fwd_llg <= w_age_llg_x[HIST_AW-1:0] == '0;
        end
    end

    // Window sum update; a trace start begins from cleared sums.
    always_comb begin
        w_s_l   = !r_s1_use_l   ? '0 : (r_s1_fwd_l   ? r_s1_x : r_rd_l);
        w_s_lg  = !r_s1_use_lg  ? '0 : (r_s1_fwd_lg  ? r_s1_x : r_rd_lg);
        w_s_llg = !r_s1_use_llg ? '0 : (r_s1_fwd_llg ? r_s1_x : r_rd_llg);
        w_base  = r_s1_ts ? '0 : r_sums;
        n_sums.trail = w_base.trail + SUM_W'(r_s1_x) - SUM_W'(w_s_l);
        n_sums.gap   = w_base.gap   + SUM_W'(w_s_l)  - SUM_W'(w_s_lg);
        n_sums.lead  = w_base.lead  + SUM_W'(w_s_lg) - SUM_W'(w_s_llg);
    end

    // The sums change only when an item leaves the first stage, so while an
    // item is in the second stage they hold exactly that item's sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (w_adv && r_s1_valid) begin
            r_sums <= n_sums;
        end
    end

    // Item tags travelling beside the weighting pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ts   <= r_s1_ts;
            r_s2_full <= r_s1_full;
            r_s3_ts   <= r_s2_ts;
            r_s3_full <= r_s2_full;
            r_s4_ts   <= r_s3_ts;
            r_s4_full <= r_s3_full;
            r_s5_ts   <= r_s4_ts;
            r_s5_full <= r_s4_full;
        end
    end

    assign w_mac_cfg.lead_coef  = r_lead_coef;
    assign w_mac_cfg.trail_coef = r_trail_coef;
    assign w_mac_cfg.lbase      = r_lbase;
    assign w_mac_cfg.gbase      = r_gbase;

    tef_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_sums (r_sums),
        .i_cfg  (w_mac_cfg),
        .o_filt (w_filt_raw)
    );

    // Filter value, zero until the trapezoid is full; trigger on the integer
    // part truncated toward zero.
    always_comb begin
        w_filt  = r_s5_full ? w_filt_raw : '0;
        w_delay = CD_W'(w_len_l) + CD_W'(r_gap_len) - CD_W'(1);
        if (!w_filt[OUT_W-1]) begin
            w_trig = (w_filt >>> 4) >= $signed({{(OUT_W-TRIG_W){1'b0}}, r_trigger});
        end else begin
            w_trig = (r_trigger == '0) && (w_filt > -$signed(OUT_W'(16)));
        end
    end

    // Pick sequencing: arm on the first trigger, report after the delay.
    always_comb begin
        n_armed  = r_s5_ts ? 1'b0 : r_armed;
        n_done   = r_s5_ts ? 1'b0 : r_done;
        n_cd     = r_s5_ts ? '0 : r_cd;
        n_evalid = 1'b0;
        if (n_armed) begin
            if (n_cd != '0) begin
                n_cd = n_cd - CD_W'(1);
            end
            if (n_cd == '0) begin
                n_evalid = 1'b1;
                n_armed  = 1'b0;
                n_done   = 1'b1;
            end
        end else if (!n_done && w_trig) begin
            if (w_delay == '0) begin
                n_evalid = 1'b1;
                n_done   = 1'b1;
            end else begin
                n_armed = 1'b1;
                n_cd    = w_delay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_done  <= 1'b0;
            r_cd    <= '0;
        end else if (w_adv && r_s5_valid) begin
            r_armed <= n_armed;
            r_done  <= n_done;
            r_cd    <= n_cd;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s5_valid) begin
            r_out_item.filter_value <= w_filt;
            r_out_item.energy       <= n_evalid ? w_filt : '0;
            r_out_item.energy_valid <= n_evalid;
        end
    end

endmodule

// ===== rtl/core/tef_mac.sv =====
// Three-stage weighting pipeline: window terms, coefficient products, rounding.
// Depends on tef_pkg.
`timescale 1ns / 1ps

module tef_mac import tef_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_sums                   i_sums,
    input  t_mac_cfg                i_cfg,
    output logic signed [OUT_W-1:0] o_filt
);

    localparam int TERM_W = SUM_W + 5;
    localparam int PROD_W = LCOEF_W + TERM_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC_SHIFT = 16;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);

    logic signed [TERM_W-1:0] w_term_l, w_term_g, w_term_t;
    logic signed [TERM_W-1:0] r_term_l, r_term_g, r_term_t;
    logic signed [PROD_W-1:0] r_prod_l, r_prod_g, r_prod_t;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [OUT_W-1:0]  r_filt;

    // Window terms with four fractional bits: 16*sum - len*baseline.
    always_comb begin
        w_term_l = $signed({1'b0, i_sums.lead,  4'b0000}) - $signed({1'b0, i_cfg.lbase});
        w_term_g = $signed({1'b0, i_sums.gap,   4'b0000}) - $signed({1'b0, i_cfg.gbase});
        w_term_t = $signed({1'b0, i_sums.trail, 4'b0000}) - $signed({1'b0, i_cfg.lbase});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term_l <= w_term_l;
            r_term_g <= w_term_g;
            r_term_t <= w_term_t;
        end
    end

    // Weighting; the gap weight is exactly one, so it is a shift.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_l <= PROD_W'(r_term_l) * PROD_W'(i_cfg.lead_coef);
            r_prod_t <= PROD_W'(r_term_t) * PROD_W'($signed({1'b0, i_cfg.trail_coef}));
            r_prod_g <= PROD_W'(r_term_g) <<< FRAC_SHIFT;
        end
    end

    // Exact sum, round half up to four fractional bits. The rounded value
    // spans fewer than 48 bits, so the output limit is never reached.
    always_comb begin
        w_acc = ACC_W'(r_prod_l) + ACC_W'(r_prod_g) + ACC_W'(r_prod_t) + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_filt <= OUT_W'($signed(w_acc[ACC_W-1:FRAC_SHIFT]));
        end
    end

    assign o_filt = r_filt;

endmodule

// ===== sim/tb_trapezoidal_energy_filter_top.sv =====
// Self-checking testbench for trapezoidal_energy_filter_top.
// Depends on tef_pkg; a predictor of the filter runs beside the block and checks each item.
`timescale 1ns / 1ps

module tb_trapezoidal_energy_filter_top;
    import tef_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT  = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    trapezoidal_energy_filter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Filter shadow state: settings, history ring, window sums and pick control.
    logic [LEN_W-1:0]          sh_rise_len;
    logic [LEN_W-1:0]          sh_gap_len;
    logic [BASE_W-1:0]         sh_baseline;
    logic signed [LCOEF_W-1:0] sh_lead_coef;
    logic [TCOEF_W-1:0]        sh_trail_coef;
    logic [TRIG_W-1:0]         sh_trigger;

    logic [IN_W-1:0]   history [HIST_DEPTH];
    int                history_pos;
    logic [SUM_W-1:0]  lead_sum;
    logic [SUM_W-1:0]  gap_sum;
    logic [SUM_W-1:0]  trail_sum;
    logic [FILL_W-1:0] fill_count;
    logic              pick_armed;
    logic              pick_done;
    logic [CD_W-1:0]   pick_countdown;

    t_out_item pending_outputs[$];
    int        mismatches;
    int        items_sent;
    bit        quiet;

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit, far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("trapezoidal_energy_filter_top: mismatch");
        $finish;
    end

    function automatic logic [IN_W-1:0] history_at(int age);
        return history[(history_pos + HIST_DEPTH - (age % HIST_DEPTH)) % HIST_DEPTH];
    endfunction

    function automatic longint window_term(logic [SUM_W-1:0] sum, int len);
        longint s;
        longint b;
        s = sum;
        b = sh_baseline;
        return s * 16 - longint'(len) * b;
    endfunction

    // Predicts the result item of one accepted sample and advances the shadow state.
    function automatic t_out_item filter_sample(t_in_item it);
        t_out_item res;
        int        len_l;
        int        len_g;
        int        n;
        int        delay;
        logic [IN_W-1:0] s_l;
        logic [IN_W-1:0] s_lg;
        logic [IN_W-1:0] s_llg;
        longint    acc;
        longint    filt;
        longint    lc;
        longint    tc;
        longint    trig;
        longint    energy;
        bit        valid;

        len_l  = (sh_rise_len == 0) ? 1 : int'(sh_rise_len);
        len_g  = sh_gap_len;
        filt   = 0;
        energy = 0;
        valid  = 1'b0;

        if (it.trace_start) begin
            lead_sum       = '0;
            gap_sum        = '0;
            trail_sum      = '0;
            fill_count     = '0;
            pick_armed     = 1'b0;
            pick_done      = 1'b0;
            pick_countdown = '0;
        end

        history_pos = (history_pos + 1) % HIST_DEPTH;
        history[history_pos] = it.sample;
        if (fill_count != FILL_MAX)
            fill_count = fill_count + 1'b1;
        n = fill_count;

        // Running sums: each window gains the sample entering it and loses the one leaving.
        s_l   = (len_l < n) ? history_at(len_l) : '0;
        s_lg  = (len_l + len_g < n) ? history_at(len_l + len_g) : '0;
        s_llg = (2 * len_l + len_g < n) ? history_at(2 * len_l + len_g) : '0;
        trail_sum = trail_sum + it.sample - s_l;
        gap_sum   = gap_sum + s_l - s_lg;
        lead_sum  = lead_sum + s_lg - s_llg;

        if (n >= 2 * len_l + len_g) begin
            lc   = sh_lead_coef;
            tc   = sh_trail_coef;
            acc  = lc * window_term(lead_sum, len_l)
                 + 64'sd65536 * window_term(gap_sum, len_g)
                 + tc * window_term(trail_sum, len_l);
            filt = (acc + 64'sd32768) >>> 16;
            if (filt > 64'sd140737488355327)
                filt = 64'sd140737488355327;
            if (filt < -64'sd140737488355328)
                filt = -64'sd140737488355328;
        end

        // Energy pick: one per trace, taken L+G-1 samples after the trigger.
        trig = sh_trigger;
        if (pick_armed) begin
            if (pick_countdown != 0)
                pick_countdown = pick_countdown - 1'b1;
            if (pick_countdown == 0) begin
                valid      = 1'b1;
                energy     = filt;
                pick_armed = 1'b0;
                pick_done  = 1'b1;
            end
        end else if (!pick_done && (filt / 16) >= trig) begin
            delay = len_l + len_g - 1;
            if (delay == 0) begin
                valid     = 1'b1;
                energy    = filt;
                pick_done = 1'b1;
            end else begin
                pick_armed     = 1'b1;
                pick_countdown = delay[CD_W-1:0];
            end
        end

        res.filter_value = filt[OUT_W-1:0];
        res.energy       = valid ? energy[OUT_W-1:0] : '0;
        res.energy_valid = valid;
        return res;
    endfunction

    // Writes one register at a falling edge; the enable is lowered by set_filter.
    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        case (idx)
            CFG_RISE_LEN:   sh_rise_len   = data[LEN_W-1:0];
            CFG_GAP_LEN:    sh_gap_len    = data[LEN_W-1:0];
            CFG_BASELINE:   sh_baseline   = data[BASE_W-1:0];
            CFG_LEAD_COEF:  sh_lead_coef  = data[LCOEF_W-1:0];
            CFG_TRAIL_COEF: sh_trail_coef = data[TCOEF_W-1:0];
            CFG_TRIGGER:    sh_trigger    = data[TRIG_W-1:0];
            default: ;
        endcase
    endtask

    // Loads a complete filter setting; only called while the block is idle.
    task automatic set_filter(int rise, int gap, int base, logic signed [LCOEF_W-1:0] lead,
                              int trail, int trig);
        write_reg(CFG_RISE_LEN, CFG_W'(rise));
        write_reg(CFG_GAP_LEN, CFG_W'(gap));
        write_reg(CFG_BASELINE, CFG_W'(base));
        write_reg(CFG_LEAD_COEF, lead);
        write_reg(CFG_TRAIL_COEF, CFG_W'(trail));
        write_reg(CFG_TRIGGER, CFG_W'(trig));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Sends one sample item, with an occasional idle burst in front of it.
    task automatic send_sample(logic [IN_W-1:0] sample, logic start);
        t_in_item  it;
        t_out_item pred;
        it.sample      = sample;
        it.trace_start = start;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = filter_sample(it);
        pending_outputs.insert(pending_outputs.size(), pred);
        items_sent++;
    endtask

    // Stops the input and waits until every predicted item has come out.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sends one trace: flat baseline, small noise, decaying step, noise_pct% random items.
    task automatic send_trace(int len, bit fresh, int base, int amp, int pos, int noise_pct);
        int v;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_sample(IN_W'($urandom), 1'($urandom));
            end else begin
                v = base + $urandom_range(0, 7);
                if (i >= pos)
                    v = v + (amp >> ((i - pos) >> 3));
                if (v > 65535)
                    v = 65535;
                send_sample(IN_W'(v), fresh && i == 0);
            end
        end
    endtask

    // A zero rise length acts as one; with no delay the energy comes on the trigger sample.
    task automatic test_zero_rise_instant_pick();
        set_filter(0, 0, 0, '0, 65536, 0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        wait_for_results();
    endtask

    // Extreme baseline, coefficients and trigger level on full-scale samples.
    task automatic test_coef_extremes();
        set_filter(1, 0, 20'hFFFFF, 26'sh2000000, 25'h1FFFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        wait_for_results();
    endtask

    // A new trace during the pick countdown drops the pick; the next trace completes one.
    task automatic test_pick_cancelled_by_new_trace();
        set_filter(2, 1, 0, '0, 65536, 1);
        send_trace(6, 1'b1, 0, 100, 4, 0);
        send_trace(9, 1'b1, 0, 100, 4, 0);
        wait_for_results();
    endtask

    // Widest windows on one long trace, so the fill count saturates.
    task automatic test_long_trace_saturation();
        set_filter(255, 255, 1000 * 16, -26'sd70000, 70000, 200);
        send_trace(1100, 1'b1, 1000, 3000, 770, 0);
        wait_for_results();
    endtask

    // Random settings per phase, each followed by mostly well-formed traces.
    task automatic test_random_traces();
        int start_count;
        int phase_count;
        int rise;
        int gap;
        int base_adc;
        int base;
        int lead_mag;
        int trail;
        int trig;
        int len_l;
        int len;
        int roll;
        bit fresh;
        logic signed [LCOEF_W-1:0] lead;

        start_count = items_sent;
        while (items_sent - start_count < 400) begin
            if (items_sent - start_count > 320)
                quiet = 1'b1;

            roll = $urandom_range(0, 99);
            rise = (roll < 5) ? 0 : (roll < 90) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            gap  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 10) : $urandom_range(11, 40);

            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                base_adc = 0;
                base     = 0;
            end else if (roll < 10) begin
                base_adc = 65535;
                base     = 20'hFFFFF;
            end else begin
                base_adc = $urandom_range(0, 50000);
                base     = base_adc * 16 + $urandom_range(0, 15);
            end

            roll = $urandom_range(0, 99);
            lead_mag = (roll < 70) ? $urandom_range(60000, 300000) :
                       (roll < 90) ? $urandom_range(0, 33554432) :
                       (roll < 95) ? 0 : 33554432;
            lead = LCOEF_W'(-lead_mag);

            trail = ($urandom_range(0, 99) < 70) ? $urandom_range(60000, 200000)
                                                 : $urandom_range(0, 33554431);
            roll = $urandom_range(0, 99);
            trig = (roll < 70) ? $urandom_range(0, 300) :
                   (roll < 90) ? $urandom_range(0, 65535) :
                   (roll < 95) ? 65535 : 0;

            set_filter(rise, gap, base, lead, trail, trig);

            // The first trace of a phase sometimes carries on the previous one.
            len_l = (rise == 0) ? 1 : rise;
            fresh = ($urandom_range(0, 99) >= 30);
            phase_count = 0;
            while (phase_count < 80) begin
                len = 3 * len_l + 2 * gap + $urandom_range(5, 40);
                send_trace(len, fresh, base_adc, $urandom_range(0, 65535 - base_adc),
                           $urandom_range(0, len - 1), 6);
                phase_count += len;
                fresh = 1'b1;
            end
            wait_for_results();
        end
    endtask

    // Receiver side: ready drops in random bursts until the quiet part of the run.
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 99) < 12) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    task automatic report_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
    endtask

    // Output checker: each accepted item is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                report_field("unexpected item, filter_value", '0, o_out_item.filter_value);
            end else begin
                due = pending_outputs.pop_front();
                if (o_out_item.filter_value !== due.filter_value)
                    report_field("filter_value", due.filter_value, o_out_item.filter_value);
                if (o_out_item.energy !== due.energy)
                    report_field("energy", due.energy, o_out_item.energy);
                if (o_out_item.energy_valid !== due.energy_valid)
                    report_field("energy_valid", OUT_W'(due.energy_valid),
                                 OUT_W'(o_out_item.energy_valid));
            end
        end
    end

    // Main sequence: reset, directed tests, random traces, then the verdict.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_RISE_LEN;
        i_cfg_data  = '0;
        mismatches  = 0;
        items_sent  = 0;
        quiet       = 1'b0;

        sh_rise_len    = 8'd27;
        sh_gap_len     = 8'd16;
        sh_baseline    = '0;
        sh_lead_coef   = '0;
        sh_trail_coef  = 25'd65536;
        sh_trigger     = 16'd10;
        history_pos    = 0;
        lead_sum       = '0;
        gap_sum        = '0;
        trail_sum      = '0;
        fill_count     = '0;
        pick_armed     = 1'b0;
        pick_done      = 1'b0;
        pick_countdown = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_rise_instant_pick();
        test_coef_extremes();
        test_pick_cancelled_by_new_trace();
        test_long_trace_saturation();
        test_random_traces();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("trapezoidal_energy_filter_top: match");
        else
            $display("trapezoidal_energy_filter_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tef_pkg.sv
rtl/core/tef_mac.sv
rtl/core/trapezoidal_energy_filter_top.sv
sim/tb_trapezoidal_energy_filter_top.sv
